/* rtl/bba_pkg.sv */
package bba_pkg;

	localparam int MAX_BLOCKS_DEF = 32;

	localparam logic [4:0] RESET_ORDER = 5'd10;

	// register index taken from paddr[2]
	localparam logic IDX_TOTAL_ORDER = 1'b0;

	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_INIT,
		CM_ROTATE,
		CM_SPLIT,
		CM_OWN
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t  mode;
		logic [15:0] owner;
		logic [4:0]  init_order;
	} cell_ctl_t;

	// smallest k with 2^k >= size; 0 and 1 give 0
	function automatic logic [5:0] order_of(input logic [31:0] size);
		logic [31:0] v;
		logic [5:0]  k;
		v = size - 32'd1;
		k = '0;
		if (size > 32'd1) begin
			for (int b = 0; b < 32; b++) begin
				if (v[b]) begin
					k = 6'(b + 1);
				end
			end
		end
		return k;
	endfunction

endpackage

/* rtl/buddy_block_allocator_top.sv */
// Query: busy for the list scan and the decide state; one result per block, given during the scan.
// Allocate: busy for the list scan and the decide state, plus a split state per split and an
// own state when a split is needed; the single result follows the last busy cycle.
// The scan rotates the cell chain once around, one slot per cycle. Results cannot be stalled.
// Reset (arst_n low): total_order = 10 and the list holds one free block of that order.
module buddy_block_allocator_top #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [15:0] owner_id,
	input  logic [31:0] request_size,
	output logic        done,
	output logic        status,
	output logic [5:0]  block_count,
	output logic [15:0] block_owner,
	output logic        last
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);

	logic [4:0]         total_order_q;
	logic               cfg_wr;
	bba_pkg::cell_ctl_t cell_ctl;
	logic [IDX_W-1:0]   sel;
	logic [4:0]         c_order [MAX_BLOCKS];
	logic [15:0]        c_owner [MAX_BLOCKS];

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == bba_pkg::IDX_TOTAL_ORDER);
	assign prdata = (paddr[2] == bba_pkg::IDX_TOTAL_ORDER) ? {27'd0, total_order_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_order_q <= bba_pkg::RESET_ORDER;
		end else if (cfg_wr) begin
			total_order_q <= pwdata[4:0];
		end
	end

	for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
		localparam int L = (j == 0) ? 0 : j - 1;
		localparam int R = (j + 1) % MAX_BLOCKS;

		bba_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (j)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (cell_ctl),
			.sel         (sel),
			.left_order  (c_order[L]),
			.left_owner  (c_owner[L]),
			.right_order (c_order[R]),
			.right_owner (c_owner[R]),
			.order       (c_order[j]),
			.owner       (c_owner[j])
		);
	end

	bba_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.operation    (operation),
		.owner_id     (owner_id),
		.request_size (request_size),
		.busy         (busy),
		.cfg_wr       (cfg_wr),
		.cfg_order    (pwdata[4:0]),
		.head_order   (c_order[0]),
		.head_owner   (c_owner[0]),
		.cell_ctl     (cell_ctl),
		.sel          (sel),
		.done         (done),
		.status       (status),
		.block_count  (block_count),
		.block_owner  (block_owner),
		.last         (last)
	);

endmodule

/* rtl/bba_cell.sv */
module bba_cell #(
	parameter int IDX_W    = 5,
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bba_pkg::cell_ctl_t  ctl,
	input  logic [IDX_W-1:0]    sel,
	input  logic [4:0]          left_order,
	input  logic [15:0]         left_owner,
	input  logic [4:0]          right_order,
	input  logic [15:0]         right_owner,
	output logic [4:0]          order,
	output logic [15:0]         owner
);

	localparam logic [IDX_W:0] ME = (IDX_W+1)'(CELL_IDX);

	logic [4:0]     order_q;
	logic [15:0]    owner_q;
	logic [IDX_W:0] sel_x;
	logic [IDX_W:0] sel_p1;

	assign sel_x  = {1'b0, sel};
	assign sel_p1 = sel_x + (IDX_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= (CELL_IDX == 0) ? bba_pkg::RESET_ORDER : 5'd0;
			owner_q <= '0;
		end else begin
			unique case (ctl.mode)
				bba_pkg::CM_INIT: begin
					order_q <= (CELL_IDX == 0) ? ctl.init_order : 5'd0;
					owner_q <= '0;
				end
				bba_pkg::CM_ROTATE: begin
					order_q <= right_order;
					owner_q <= right_owner;
				end
				bba_pkg::CM_SPLIT: begin
					if (ME == sel_x) begin
						order_q <= order_q - 5'd1;
					end else if (ME == sel_p1) begin
						order_q <= left_order - 5'd1;
						owner_q <= '0;
					end else if (ME > sel_p1) begin
						order_q <= left_order;
						owner_q <= left_owner;
					end
				end
				bba_pkg::CM_OWN: begin
					if (ME == sel_x) begin
						owner_q <= ctl.owner;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign order = order_q;
	assign owner = owner_q;

endmodule

/* rtl/bba_ctrl.sv */
module bba_ctrl #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
	localparam int IDX_W  = $clog2(MAX_BLOCKS),
	localparam int USED_W = $clog2(MAX_BLOCKS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               operation,
	input  logic [15:0]        owner_id,
	input  logic [31:0]        request_size,
	output logic               busy,
	input  logic               cfg_wr,
	input  logic [4:0]         cfg_order,
	input  logic [4:0]         head_order,
	input  logic [15:0]        head_owner,
	output bba_pkg::cell_ctl_t cell_ctl,
	output logic [IDX_W-1:0]   sel,
	output logic               done,
	output logic               status,
	output logic [5:0]         block_count,
	output logic [15:0]        block_owner,
	output logic               last
);

	localparam int SUM_W = USED_W + 6;
	localparam logic [IDX_W-1:0] STEP_END = IDX_W'(MAX_BLOCKS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SPLIT,
		ST_OWN
	} state_t;

	state_t            state_q;
	logic              op_q;
	logic [15:0]       owner_q;
	logic [5:0]        k_q;
	logic [IDX_W-1:0]  step_q;
	logic              exact_hit_q;
	logic [IDX_W-1:0]  exact_idx_q;
	logic              big_hit_q;
	logic [IDX_W-1:0]  big_idx_q;
	logic [4:0]        big_order_q;
	logic [4:0]        split_left_q;
	logic [USED_W-1:0] used_q;
	logic              done_q;
	logic              status_q;
	logic [5:0]        count_q;
	logic [15:0]       bowner_q;
	logic              last_q;

	logic              in_list;
	logic              head_free;
	logic [4:0]        split_cnt;
	logic              fits;

	assign busy      = (state_q != ST_IDLE);
	assign in_list   = (USED_W'(step_q) < used_q);
	assign head_free = (head_owner == 16'd0);
	assign split_cnt = big_order_q - k_q[4:0];
	assign fits      = (SUM_W'(used_q) + SUM_W'(split_cnt)) <= SUM_W'(MAX_BLOCKS);

	always_comb begin
		cell_ctl.mode       = bba_pkg::CM_HOLD;
		cell_ctl.owner      = owner_q;
		cell_ctl.init_order = cfg_order;
		sel                 = big_idx_q;
		if (cfg_wr) begin
			cell_ctl.mode = bba_pkg::CM_INIT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_SCAN: cell_ctl.mode = bba_pkg::CM_ROTATE;
				ST_DECIDE: begin
					if (op_q == bba_pkg::OP_ALLOC && owner_q != 16'd0 && exact_hit_q) begin
						cell_ctl.mode = bba_pkg::CM_OWN;
						sel           = exact_idx_q;
					end
				end
				ST_SPLIT: cell_ctl.mode = bba_pkg::CM_SPLIT;
				ST_OWN:   cell_ctl.mode = bba_pkg::CM_OWN;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= bba_pkg::OP_QUERY;
			owner_q      <= '0;
			k_q          <= '0;
			step_q       <= '0;
			exact_hit_q  <= 1'b0;
			exact_idx_q  <= '0;
			big_hit_q    <= 1'b0;
			big_idx_q    <= '0;
			big_order_q  <= '0;
			split_left_q <= '0;
			used_q       <= USED_W'(1);
			done_q       <= 1'b0;
			status_q     <= bba_pkg::STATUS_OK;
			count_q      <= '0;
			bowner_q     <= '0;
			last_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				used_q <= USED_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q        <= operation;
						owner_q     <= owner_id;
						k_q         <= bba_pkg::order_of(request_size);
						step_q      <= '0;
						exact_hit_q <= 1'b0;
						big_hit_q   <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (in_list) begin
						if (op_q == bba_pkg::OP_QUERY) begin
							done_q   <= 1'b1;
							status_q <= bba_pkg::STATUS_OK;
							count_q  <= 6'(used_q);
							bowner_q <= head_owner;
							last_q   <= (USED_W'(step_q) == used_q - USED_W'(1));
						end
						if (head_free && !exact_hit_q && {1'b0, head_order} == k_q) begin
							exact_hit_q <= 1'b1;
							exact_idx_q <= step_q;
						end
						if (head_free && !big_hit_q && {1'b0, head_order} > k_q) begin
							big_hit_q   <= 1'b1;
							big_idx_q   <= step_q;
							big_order_q <= head_order;
						end
					end
					step_q <= step_q + IDX_W'(1);
					if (step_q == STEP_END) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_IDLE;
					if (op_q == bba_pkg::OP_ALLOC) begin
						count_q  <= 6'(used_q);
						bowner_q <= owner_q;
						last_q   <= 1'b1;
						if (owner_q != 16'd0 && exact_hit_q) begin
							done_q   <= 1'b1;
							status_q <= bba_pkg::STATUS_OK;
						end else if (owner_q != 16'd0 && big_hit_q && fits) begin
							split_left_q <= split_cnt;
							state_q      <= ST_SPLIT;
						end else begin
							done_q   <= 1'b1;
							status_q <= bba_pkg::STATUS_FAIL;
						end
					end
				end
				ST_SPLIT: begin
					used_q       <= used_q + USED_W'(1);
					split_left_q <= split_left_q - 5'd1;
					if (split_left_q == 5'd1) begin
						state_q <= ST_OWN;
					end
				end
				ST_OWN: begin
					done_q   <= 1'b1;
					status_q <= bba_pkg::STATUS_OK;
					count_q  <= 6'(used_q);
					bowner_q <= owner_q;
					last_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign block_count = count_q;
	assign block_owner = bowner_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != '0 && SUM_W'(used_q) <= SUM_W'(MAX_BLOCKS))
		else $error("block count out of range");

	a_split_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SPLIT |=> used_q == $past(used_q) + USED_W'(1))
		else $error("split did not add a block");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == bba_pkg::STATUS_FAIL |-> USED_W'(count_q) == used_q
		|| MAX_BLOCKS == 64)
		else $error("failed request changed the list");

	a_query_no_split: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SPLIT |-> op_q == bba_pkg::OP_ALLOC && owner_q != 16'd0)
		else $error("split outside an allocate request");
`endif

endmodule
